@@ src/sm4_pkg.sv @@
package sm4_pkg;

    typedef struct packed {
        logic [63:0] plain_upper;
        logic [63:0] plain_lower;
    } sm4_in_t;

    typedef struct packed {
        logic [63:0] cipher_upper;
        logic [63:0] cipher_lower;
    } sm4_out_t;

    typedef logic [31:0] word_t;

    localparam int unsigned NumRounds = 32;

    localparam logic REG_KEY_UPPER = 1'b0;
    localparam logic REG_KEY_LOWER = 1'b1;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'hd6; 8'h01: r = 8'h90; 8'h02: r = 8'he9; 8'h03: r = 8'hfe;
            8'h04: r = 8'hcc; 8'h05: r = 8'he1; 8'h06: r = 8'h3d; 8'h07: r = 8'hb7;
            8'h08: r = 8'h16; 8'h09: r = 8'hb6; 8'h0a: r = 8'h14; 8'h0b: r = 8'hc2;
            8'h0c: r = 8'h28; 8'h0d: r = 8'hfb; 8'h0e: r = 8'h2c; 8'h0f: r = 8'h05;
            8'h10: r = 8'h2b; 8'h11: r = 8'h67; 8'h12: r = 8'h9a; 8'h13: r = 8'h76;
            8'h14: r = 8'h2a; 8'h15: r = 8'hbe; 8'h16: r = 8'h04; 8'h17: r = 8'hc3;
            8'h18: r = 8'haa; 8'h19: r = 8'h44; 8'h1a: r = 8'h13; 8'h1b: r = 8'h26;
            8'h1c: r = 8'h49; 8'h1d: r = 8'h86; 8'h1e: r = 8'h06; 8'h1f: r = 8'h99;
            8'h20: r = 8'h9c; 8'h21: r = 8'h42; 8'h22: r = 8'h50; 8'h23: r = 8'hf4;
            8'h24: r = 8'h91; 8'h25: r = 8'hef; 8'h26: r = 8'h98; 8'h27: r = 8'h7a;
            8'h28: r = 8'h33; 8'h29: r = 8'h54; 8'h2a: r = 8'h0b; 8'h2b: r = 8'h43;
            8'h2c: r = 8'hed; 8'h2d: r = 8'hcf; 8'h2e: r = 8'hac; 8'h2f: r = 8'h62;
            8'h30: r = 8'he4; 8'h31: r = 8'hb3; 8'h32: r = 8'h1c; 8'h33: r = 8'ha9;
            8'h34: r = 8'hc9; 8'h35: r = 8'h08; 8'h36: r = 8'he8; 8'h37: r = 8'h95;
            8'h38: r = 8'h80; 8'h39: r = 8'hdf; 8'h3a: r = 8'h94; 8'h3b: r = 8'hfa;
            8'h3c: r = 8'h75; 8'h3d: r = 8'h8f; 8'h3e: r = 8'h3f; 8'h3f: r = 8'ha6;
            8'h40: r = 8'h47; 8'h41: r = 8'h07; 8'h42: r = 8'ha7; 8'h43: r = 8'hfc;
            8'h44: r = 8'hf3; 8'h45: r = 8'h73; 8'h46: r = 8'h17; 8'h47: r = 8'hba;
            8'h48: r = 8'h83; 8'h49: r = 8'h59; 8'h4a: r = 8'h3c; 8'h4b: r = 8'h19;
            8'h4c: r = 8'he6; 8'h4d: r = 8'h85; 8'h4e: r = 8'h4f; 8'h4f: r = 8'ha8;
            8'h50: r = 8'h68; 8'h51: r = 8'h6b; 8'h52: r = 8'h81; 8'h53: r = 8'hb2;
            8'h54: r = 8'h71; 8'h55: r = 8'h64; 8'h56: r = 8'hda; 8'h57: r = 8'h8b;
            8'h58: r = 8'hf8; 8'h59: r = 8'heb; 8'h5a: r = 8'h0f; 8'h5b: r = 8'h4b;
            8'h5c: r = 8'h70; 8'h5d: r = 8'h56; 8'h5e: r = 8'h9d; 8'h5f: r = 8'h35;
            8'h60: r = 8'h1e; 8'h61: r = 8'h24; 8'h62: r = 8'h0e; 8'h63: r = 8'h5e;
            8'h64: r = 8'h63; 8'h65: r = 8'h58; 8'h66: r = 8'hd1; 8'h67: r = 8'ha2;
            8'h68: r = 8'h25; 8'h69: r = 8'h22; 8'h6a: r = 8'h7c; 8'h6b: r = 8'h3b;
            8'h6c: r = 8'h01; 8'h6d: r = 8'h21; 8'h6e: r = 8'h78; 8'h6f: r = 8'h87;
            8'h70: r = 8'hd4; 8'h71: r = 8'h00; 8'h72: r = 8'h46; 8'h73: r = 8'h57;
            8'h74: r = 8'h9f; 8'h75: r = 8'hd3; 8'h76: r = 8'h27; 8'h77: r = 8'h52;
            8'h78: r = 8'h4c; 8'h79: r = 8'h36; 8'h7a: r = 8'h02; 8'h7b: r = 8'he7;
            8'h7c: r = 8'ha0; 8'h7d: r = 8'hc4; 8'h7e: r = 8'hc8; 8'h7f: r = 8'h9e;
            8'h80: r = 8'hea; 8'h81: r = 8'hbf; 8'h82: r = 8'h8a; 8'h83: r = 8'hd2;
            8'h84: r = 8'h40; 8'h85: r = 8'hc7; 8'h86: r = 8'h38; 8'h87: r = 8'hb5;
            8'h88: r = 8'ha3; 8'h89: r = 8'hf7; 8'h8a: r = 8'hf2; 8'h8b: r = 8'hce;
            8'h8c: r = 8'hf9; 8'h8d: r = 8'h61; 8'h8e: r = 8'h15; 8'h8f: r = 8'ha1;
            8'h90: r = 8'he0; 8'h91: r = 8'hae; 8'h92: r = 8'h5d; 8'h93: r = 8'ha4;
            8'h94: r = 8'h9b; 8'h95: r = 8'h34; 8'h96: r = 8'h1a; 8'h97: r = 8'h55;
            8'h98: r = 8'had; 8'h99: r = 8'h93; 8'h9a: r = 8'h32; 8'h9b: r = 8'h30;
            8'h9c: r = 8'hf5; 8'h9d: r = 8'h8c; 8'h9e: r = 8'hb1; 8'h9f: r = 8'he3;
            8'ha0: r = 8'h1d; 8'ha1: r = 8'hf6; 8'ha2: r = 8'he2; 8'ha3: r = 8'h2e;
            8'ha4: r = 8'h82; 8'ha5: r = 8'h66; 8'ha6: r = 8'hca; 8'ha7: r = 8'h60;
            8'ha8: r = 8'hc0; 8'ha9: r = 8'h29; 8'haa: r = 8'h23; 8'hab: r = 8'hab;
            8'hac: r = 8'h0d; 8'had: r = 8'h53; 8'hae: r = 8'h4e; 8'haf: r = 8'h6f;
            8'hb0: r = 8'hd5; 8'hb1: r = 8'hdb; 8'hb2: r = 8'h37; 8'hb3: r = 8'h45;
            8'hb4: r = 8'hde; 8'hb5: r = 8'hfd; 8'hb6: r = 8'h8e; 8'hb7: r = 8'h2f;
            8'hb8: r = 8'h03; 8'hb9: r = 8'hff; 8'hba: r = 8'h6a; 8'hbb: r = 8'h72;
            8'hbc: r = 8'h6d; 8'hbd: r = 8'h6c; 8'hbe: r = 8'h5b; 8'hbf: r = 8'h51;
            8'hc0: r = 8'h8d; 8'hc1: r = 8'h1b; 8'hc2: r = 8'haf; 8'hc3: r = 8'h92;
            8'hc4: r = 8'hbb; 8'hc5: r = 8'hdd; 8'hc6: r = 8'hbc; 8'hc7: r = 8'h7f;
            8'hc8: r = 8'h11; 8'hc9: r = 8'hd9; 8'hca: r = 8'h5c; 8'hcb: r = 8'h41;
            8'hcc: r = 8'h1f; 8'hcd: r = 8'h10; 8'hce: r = 8'h5a; 8'hcf: r = 8'hd8;
            8'hd0: r = 8'h0a; 8'hd1: r = 8'hc1; 8'hd2: r = 8'h31; 8'hd3: r = 8'h88;
            8'hd4: r = 8'ha5; 8'hd5: r = 8'hcd; 8'hd6: r = 8'h7b; 8'hd7: r = 8'hbd;
            8'hd8: r = 8'h2d; 8'hd9: r = 8'h74; 8'hda: r = 8'hd0; 8'hdb: r = 8'h12;
            8'hdc: r = 8'hb8; 8'hdd: r = 8'he5; 8'hde: r = 8'hb4; 8'hdf: r = 8'hb0;
            8'he0: r = 8'h89; 8'he1: r = 8'h69; 8'he2: r = 8'h97; 8'he3: r = 8'h4a;
            8'he4: r = 8'h0c; 8'he5: r = 8'h96; 8'he6: r = 8'h77; 8'he7: r = 8'h7e;
            8'he8: r = 8'h65; 8'he9: r = 8'hb9; 8'hea: r = 8'hf1; 8'heb: r = 8'h09;
            8'hec: r = 8'hc5; 8'hed: r = 8'h6e; 8'hee: r = 8'hc6; 8'hef: r = 8'h84;
            8'hf0: r = 8'h18; 8'hf1: r = 8'hf0; 8'hf2: r = 8'h7d; 8'hf3: r = 8'hec;
            8'hf4: r = 8'h3a; 8'hf5: r = 8'hdc; 8'hf6: r = 8'h4d; 8'hf7: r = 8'h20;
            8'hf8: r = 8'h79; 8'hf9: r = 8'hee; 8'hfa: r = 8'h5f; 8'hfb: r = 8'h3e;
            8'hfc: r = 8'hd7; 8'hfd: r = 8'hcb; 8'hfe: r = 8'h39; 8'hff: r = 8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic word_t tau(input word_t a);
        return {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
    endfunction

    function automatic word_t mix_data(input word_t b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    function automatic word_t mix_key(input word_t b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK byte j of word i is (4*i + j) * 7 mod 256
    function automatic word_t ck_word(input logic [4:0] i);
        logic [7:0] b0, b1, b2, b3;
        b0 = 8'({i, 2'b00} * 7);
        b1 = 8'({i, 2'b01} * 7);
        b2 = 8'({i, 2'b10} * 7);
        b3 = 8'({i, 2'b11} * 7);
        return {b0, b1, b2, b3};
    endfunction

endpackage

@@ src/sm4_key_expand.sv @@
// Key schedule: one round key per cycle after reset or a start pulse.
module sm4_key_expand (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [127:0]         key,
    output logic [32*32-1:0]     round_keys,
    output logic                 busy
);
    import sm4_pkg::*;

    logic [127:0] k_reg, k_next;
    logic [4:0]   idx_reg, idx_next;
    logic         busy_reg, busy_next;
    word_t        rk_reg [NumRounds];
    word_t        nk;

    assign nk = k_reg[127:96]
              ^ mix_key(tau(k_reg[95:64] ^ k_reg[63:32] ^ k_reg[31:0] ^ ck_word(idx_reg)));

    // step control
    always_comb begin
        k_next    = k_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (start) begin
            k_next    = key ^ {FK0, FK1, FK2, FK3};
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            k_next   = {k_reg[95:0], nk};
            idx_next = idx_reg + 5'd1;
            if (idx_reg == 5'(NumRounds - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            k_reg    <= {FK0, FK1, FK2, FK3};
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !start) begin
            rk_reg[idx_reg] <= nk;
        end
    end

    for (genvar g = 0; g < NumRounds; g++) begin : g_out
        assign round_keys[32*g +: 32] = rk_reg[g];
    end

    assign busy = busy_reg;

    a_idx_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> idx_reg == '0 || $past(idx_reg) == 5'(NumRounds - 1))
        else $error("key index left nonzero");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && idx_reg == '0)
        else $error("start did not begin expansion");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start && idx_reg == 5'(NumRounds - 1) |=> !busy_reg)
        else $error("expansion did not finish");

endmodule

@@ src/sm4_block_encrypt.sv @@
// Channel | Ports               | Payload
// input   | s_valid / s_ready   | sm4_in_t  (plain_upper, plain_lower)
// result  | m_valid / m_ready   | sm4_out_t (cipher_upper, cipher_lower)
// config  | APB psel..pready    | key_upper at 0x0, key_lower at 0x8
//
// One round per pipeline stage: 32 stages, one item per cycle unless m_ready stalls or the key schedule runs.
// Each item is registered in every stage, x_reg[0] through x_reg[NumRounds-1], in turn.
// The schedule runs after reset and after a key write (key_start latches
// the write, then 32 steps); s_ready is low meanwhile.
// Reset is synchronous, active low; it clears valid bits and loads the zero key.
// A stall on m_ready holds the whole pipeline; items are neither lost nor repeated.
module sm4_block_encrypt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sm4_pkg::sm4_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sm4_pkg::sm4_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import sm4_pkg::*;

    logic [63:0]            key_upper_reg, key_lower_reg;
    logic                   cfg_wr, key_start, ks_busy;
    logic [32*NumRounds-1:0] rkeys;
    logic [127:0]           x_reg [NumRounds];
    logic                   v_reg [NumRounds];
    logic                   advance;
    logic [127:0]           blk;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else if (cfg_wr && paddr[2:0] == 3'b000 && paddr[3] == REG_KEY_UPPER) begin
            key_upper_reg <= pwdata;
        end else if (cfg_wr && paddr[2:0] == 3'b000 && paddr[3] == REG_KEY_LOWER) begin
            key_lower_reg <= pwdata;
        end
    end

    assign prdata = (paddr[3] == REG_KEY_UPPER) ? key_upper_reg : key_lower_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_start <= 1'b0;
        end else begin
            key_start <= cfg_wr && paddr[2:0] == 3'b000;
        end
    end

    sm4_key_expand u_keys (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (key_start),
        .key        ({key_upper_reg, key_lower_reg}),
        .round_keys (rkeys),
        .busy       (ks_busy)
    );

    // whole pipeline moves when the last stage is empty or m_ready is high
    assign advance = !v_reg[NumRounds-1] || m_ready;
    assign s_ready = advance && !ks_busy && !key_start;
    assign blk     = {s_data.plain_upper, s_data.plain_lower};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumRounds; i++) v_reg[i] <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= s_valid && s_ready;
            for (int i = 1; i < NumRounds; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // round stages: shift words, append the new one
    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg[0] <= {blk[95:0], blk[127:96] ^ mix_data(tau(
                blk[95:64] ^ blk[63:32] ^ blk[31:0] ^ rkeys[31:0]))};
            for (int i = 1; i < NumRounds; i++) begin
                x_reg[i] <= {x_reg[i-1][95:0], x_reg[i-1][127:96] ^ mix_data(tau(
                    x_reg[i-1][95:64] ^ x_reg[i-1][63:32] ^ x_reg[i-1][31:0]
                    ^ rkeys[32*i +: 32]))};
            end
        end
    end

    assign m_valid = v_reg[NumRounds-1];
    assign m_data.cipher_upper = {x_reg[NumRounds-1][31:0], x_reg[NumRounds-1][63:32]};
    assign m_data.cipher_lower = {x_reg[NumRounds-1][95:64], x_reg[NumRounds-1][127:96]};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ks_busy |-> !(s_valid && s_ready))
        else $error("item accepted during key expansion");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped during stall");
    a_key_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        key_start |=> ks_busy)
        else $error("key write did not restart expansion");

endmodule
